@@ rtl/call_depth_function_histogram_defines.svh @@
// Assertion helpers used by the checker file.
// Each expects i_clk and i_rst_n in scope.
`ifndef CALL_DEPTH_FUNCTION_HISTOGRAM_DEFINES_SVH
`define CALL_DEPTH_FUNCTION_HISTOGRAM_DEFINES_SVH

// Same-cycle implication.
`define CDFH_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("check failed");

// Next-cycle implication.
`define CDFH_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("check failed");

`endif

@@ rtl/cdfh_pkg.sv @@
`default_nettype none
package cdfh_pkg;

    localparam int TABLE_ENTRIES = 64;
    localparam int IGNORE_SLOTS  = 4;

    localparam int ADDR_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int USED_W = $clog2(TABLE_ENTRIES + 1);
    localparam int IGN_W  = (IGNORE_SLOTS > 1) ? $clog2(IGNORE_SLOTS) : 1;

    localparam int DEPTH_W  = 8;
    localparam int FID_W    = 16;
    localparam int COUNT_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int IGN_USED_W = 3;

    localparam logic [DEPTH_W-1:0] MAX_DEPTH = 8'd255;

    // action codes
    localparam logic [1:0] ACT_TRACE = 2'd0;
    localparam logic [1:0] ACT_DUMP  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // trace event kinds
    localparam logic [1:0] CODE_ENTER = 2'd0;
    localparam logic [1:0] CODE_EXIT  = 2'd1;

    // register index of the slot count; slots sit below it
    localparam logic [CFG_IDX_W-1:0] CFG_IGNORE_USED = CFG_IDX_W'(IGNORE_SLOTS);

    typedef struct packed {
        logic [1:0]       action;
        logic [1:0]       ev_kind;
        logic [FID_W-1:0] func_id;
    } t_in;

    typedef struct packed {
        logic [DEPTH_W-1:0] entry_depth;
        logic [FID_W-1:0]   entry_function;
        logic [COUNT_W-1:0] entry_count;
        logic               entry_valid;
        logic               last_entry;
        logic               table_overflow;
    } t_out;

    typedef struct packed {
        logic [DEPTH_W-1:0] depth;
        logic [FID_W-1:0]   fn_id;
        logic [COUNT_W-1:0] count;
    } t_entry;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] waddr;
        t_entry            wdata;
        logic              re;
        logic [ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage
`default_nettype wire

@@ rtl/cdfh_table.sv @@
`default_nettype none
module cdfh_table (
    input  logic               i_clk,
    input  cdfh_pkg::t_mem_req i_req,
    output cdfh_pkg::t_entry   o_rdata
);
    import cdfh_pkg::*;

    t_entry r_mem [TABLE_ENTRIES];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

@@ rtl/call_depth_function_histogram.sv @@
// Enter: written at once on an empty table, else stored entries (1..64) are scanned.
// Exit, clear, ignored and unused events: handled in idle, no output word.
// Dump: one word per entry, read in turn from one table read port; empty table gives one word.
// One item in flight; the scan through the table's single read port sets the rate.
// Sync active-low reset: depth 1, table empty, overflow and ignore registers 0.
`default_nettype none
module call_depth_function_histogram (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  cdfh_pkg::t_in                        i_data,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output cdfh_pkg::t_out                       o_data,
    input  logic                                 i_cfg_we,
    input  logic [cdfh_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [cdfh_pkg::CFG_DATA_W-1:0]      i_cfg_data
);
    import cdfh_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DUMP  = 2'd2;
    localparam logic [1:0] ST_EMPTY = 2'd3;

    logic [1:0]            r_state,     n_state;
    logic [ADDR_W-1:0]     r_idx,       n_idx;
    logic [USED_W-1:0]     r_used,      n_used;
    logic [DEPTH_W-1:0]    r_depth,     n_depth;
    logic                  r_ovf,       n_ovf;
    logic [FID_W-1:0]      r_fid,       n_fid;
    logic                  r_out_valid, n_out_valid;
    t_out                  r_out,       n_out;

    logic [FID_W-1:0]      r_ign [IGNORE_SLOTS];
    logic [IGN_USED_W-1:0] r_ign_used;

    t_mem_req              mem_req;
    t_entry                mem_rdata;

    logic [IGN_USED_W-1:0] ign_n;
    logic                  ignored;
    logic                  out_free;
    logic                  at_last;
    logic                  hit;
    logic [DEPTH_W-1:0]    depth_inc;

    cdfh_table u_table (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < IGNORE_SLOTS; i++) begin
                r_ign[i] <= '0;
            end
            r_ign_used <= '0;
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_IGNORE_USED) begin
                r_ign[i_cfg_index[IGN_W-1:0]] <= i_cfg_data[FID_W-1:0];
            end else if (i_cfg_index == CFG_IGNORE_USED) begin
                r_ign_used <= i_cfg_data[IGN_USED_W-1:0];
            end
        end
    end

    always_comb begin
        ign_n = (r_ign_used > IGN_USED_W'(IGNORE_SLOTS)) ?
                IGN_USED_W'(IGNORE_SLOTS) : r_ign_used;
        ignored = 1'b0;
        for (int i = 0; i < IGNORE_SLOTS; i++) begin
            if ((IGN_USED_W'(i) < ign_n) && (r_ign[i] == i_data.func_id)) begin
                ignored = 1'b1;
            end
        end
    end

    assign out_free  = !r_out_valid || !i_stall;
    assign at_last   = (USED_W'(r_idx) + USED_W'(1)) == r_used;
    assign hit       = (mem_rdata.depth == r_depth) && (mem_rdata.fn_id == r_fid);
    assign depth_inc = (r_depth < MAX_DEPTH) ? r_depth + DEPTH_W'(1) : r_depth;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_used      = r_used;
        n_depth     = r_depth;
        n_ovf       = r_ovf;
        n_fid       = r_fid;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        mem_req       = '0;
        mem_req.raddr = r_idx + ADDR_W'(1);

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    unique case (i_data.action)
                        ACT_TRACE: begin
                            if (!ignored) begin
                                if (i_data.ev_kind == CODE_ENTER) begin
                                    if (r_used == '0) begin
                                        mem_req.we    = 1'b1;
                                        mem_req.waddr = '0;
                                        mem_req.wdata = '{depth: r_depth,
                                                          fn_id: i_data.func_id,
                                                          count: COUNT_W'(1)};
                                        n_used  = USED_W'(1);
                                        n_depth = depth_inc;
                                    end else begin
                                        n_fid         = i_data.func_id;
                                        n_idx         = '0;
                                        mem_req.re    = 1'b1;
                                        mem_req.raddr = '0;
                                        n_state       = ST_SCAN;
                                    end
                                end else if (i_data.ev_kind == CODE_EXIT) begin
                                    if (r_depth != '0) begin
                                        n_depth = r_depth - DEPTH_W'(1);
                                    end
                                end
                            end
                        end
                        ACT_DUMP: begin
                            if (r_used == '0) begin
                                n_state = ST_EMPTY;
                            end else begin
                                n_idx         = '0;
                                mem_req.re    = 1'b1;
                                mem_req.raddr = '0;
                                n_state       = ST_DUMP;
                            end
                        end
                        ACT_CLEAR: begin
                            n_used  = '0;
                            n_depth = DEPTH_W'(1);
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                // next entry is read while this one is compared
                if (hit) begin
                    mem_req.we    = 1'b1;
                    mem_req.waddr = r_idx;
                    mem_req.wdata = mem_rdata;
                    if (mem_rdata.count != '1) begin
                        mem_req.wdata.count = mem_rdata.count + COUNT_W'(1);
                    end
                    n_depth = depth_inc;
                    n_state = ST_IDLE;
                end else if (at_last) begin
                    if (r_used == USED_W'(TABLE_ENTRIES)) begin
                        n_ovf = 1'b1;
                    end else begin
                        mem_req.we    = 1'b1;
                        mem_req.waddr = ADDR_W'(r_used);
                        mem_req.wdata = '{depth: r_depth, fn_id: r_fid,
                                          count: COUNT_W'(1)};
                        n_used = r_used + USED_W'(1);
                    end
                    n_depth = depth_inc;
                    n_state = ST_IDLE;
                end else begin
                    mem_req.re = 1'b1;
                    n_idx      = r_idx + ADDR_W'(1);
                end
            end
            ST_DUMP: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{entry_depth:    mem_rdata.depth,
                              entry_function: mem_rdata.fn_id,
                              entry_count:    mem_rdata.count,
                              entry_valid:    1'b1,
                              last_entry:     at_last,
                              table_overflow: r_ovf};
                    if (at_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        mem_req.re = 1'b1;
                        n_idx      = r_idx + ADDR_W'(1);
                    end
                end
            end
            ST_EMPTY: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out = '{entry_depth: '0, entry_function: '0, entry_count: '0,
                              entry_valid: 1'b0, last_entry: 1'b1,
                              table_overflow: r_ovf};
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_idx       <= '0;
            r_used      <= '0;
            r_depth     <= DEPTH_W'(1);
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_used      <= n_used;
            r_depth     <= n_depth;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fid <= n_fid;
        r_out <= n_out;
    end

    assign o_stall = (r_state != ST_IDLE);
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule
`default_nettype wire

@@ rtl/call_depth_function_histogram_checker.sv @@
`default_nettype none
`include "call_depth_function_histogram_defines.svh"
module call_depth_function_histogram_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_valid,
    input logic                                o_stall,
    input cdfh_pkg::t_in                       i_data,
    input logic                                o_valid,
    input logic                                i_stall,
    input cdfh_pkg::t_out                      o_data
);
    import cdfh_pkg::*;

    logic in_acc;
    assign in_acc = i_valid && !o_stall;

    // a dump always keeps the block busy in the following cycle
    `CDFH_ASSERT_NEXT(a_dump_busy, in_acc && (i_data.action == ACT_DUMP), o_stall)

    // clear leaves the block free to accept in the next cycle
    `CDFH_ASSERT_NEXT(a_clear_done, in_acc && (i_data.action == ACT_CLEAR), !o_stall)

    // empty-table word is the whole dump
    `CDFH_ASSERT_NOW(a_empty_last, o_valid && !o_data.entry_valid, o_data.last_entry)

    `CDFH_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_data))

endmodule

bind call_depth_function_histogram call_depth_function_histogram_checker u_checker (.*);
`default_nettype wire
